### hw/rtl/pfde_pkg.sv
`default_nettype none

package pfde_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH = 128;
    localparam int PAGE_COUNT   = 8;
    localparam int SCREEN_ROWS  = PAGE_COUNT * 8;
    localparam int STORE_SIZE   = PAGE_COUNT * SCREEN_WIDTH;

    // widths derived from the geometry
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int RW = PW + 3;
    localparam int AW = $clog2(STORE_SIZE);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] BIT_MASK = 3'h7;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PIXEL = 3'd1,
        OP_FILL  = 3'd2,
        OP_BLIT  = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_NOP,
        K_CLEAR,
        K_DRAW,
        K_FILL,
        K_READ
    } t_kind;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_MODIFY
    } t_state;

    // classified command, already clipped to the screen
    typedef struct packed {
        t_kind           kind;
        logic            color;
        logic [7:0]      lanes;
        logic [XW-1:0]   x_lo;
        logic [XW-1:0]   x_hi;
        logic [PW-1:0]   page_lo;
        logic [PW-1:0]   page_hi;
        logic [2:0]      bit_lo;
        logic [2:0]      bit_hi;
    } t_cmd;

    function automatic logic [AW-1:0] store_addr(input logic [PW-1:0] page,
                                                 input logic [XW-1:0] x);
        int sum;
        sum = int'(page) * SCREEN_WIDTH + int'(x);
        return AW'(sum);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pfde_ram.sv
`default_nettype none

module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/pfde_front.sv
`default_nettype none

module pfde_front
    import pfde_pkg::*;
(
    input  wire logic [2:0] i_op,
    input  wire logic [7:0] i_pos_x,
    input  wire logic [7:0] i_pos_y,
    input  wire logic [7:0] i_span_w,
    input  wire logic [7:0] i_span_h,
    input  wire logic       i_color,
    input  wire logic [7:0] i_bitmap_row,
    input  wire logic [4:0] i_byte_column,
    input  wire logic [7:0] i_bitmap_byte,
    input  wire logic [2:0] i_read_page,
    output t_cmd            o_cmd
);

    logic       x_ok;
    logic       y_ok;
    logic [8:0] x_end;
    logic [8:0] x_lim;
    logic [8:0] x_last;
    logic [8:0] y_end;
    logic [8:0] y_lim;
    logic [8:0] y_last;
    logic [8:0] blit_row;
    logic       blit_row_ok;
    logic [8:0] blit_base;
    logic [7:0] blit_lanes;
    logic       page_ok;

    always_comb begin
        x_ok   = 9'(i_pos_x) < 9'(SCREEN_WIDTH);
        y_ok   = 9'(i_pos_y) < 9'(SCREEN_ROWS);
        x_end  = 9'(i_pos_x) + 9'(i_span_w);
        x_lim  = (x_end > 9'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH) : x_end;
        x_last = x_lim - 9'd1;
        y_end  = 9'(i_pos_y) + 9'(i_span_h);
        y_lim  = (y_end > 9'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS) : y_end;
        y_last = y_lim - 9'd1;

        blit_row    = 9'(i_pos_y) + 9'(i_bitmap_row);
        blit_row_ok = (i_bitmap_row < i_span_h) && (blit_row < 9'(SCREEN_ROWS));
        blit_base   = 9'(i_pos_x) + 9'({i_byte_column, 3'b000});
        page_ok     = 6'(i_read_page) < 6'(PAGE_COUNT);
    end

    // one lane per bitmap bit, lane 0 is the leftmost pixel
    always_comb begin
        logic [8:0] col;
        logic [8:0] scr;
        for (int i = 0; i < 8; i++) begin
            col = 9'({i_byte_column, 3'b000}) + 9'(i);
            scr = 9'(i_pos_x) + col;
            blit_lanes[i] = i_bitmap_byte[7 - i] && (col < 9'(i_span_w))
                            && (scr < 9'(SCREEN_WIDTH));
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = K_NOP;
        case (i_op)
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
            end
            OP_PIXEL: begin
                if (x_ok && y_ok) begin
                    o_cmd.kind    = K_DRAW;
                    o_cmd.color   = i_color;
                    o_cmd.lanes   = 8'h01;
                    o_cmd.x_lo    = XW'(i_pos_x);
                    o_cmd.page_lo = PW'(RW'(i_pos_y) >> 3);
                    o_cmd.page_hi = PW'(RW'(i_pos_y) >> 3);
                    o_cmd.bit_lo  = i_pos_y[2:0] & BIT_MASK;
                    o_cmd.bit_hi  = i_pos_y[2:0] & BIT_MASK;
                end
            end
            OP_FILL: begin
                if (x_ok && y_ok && (i_span_w != 8'd0) && (i_span_h != 8'd0)) begin
                    o_cmd.kind    = K_FILL;
                    o_cmd.color   = i_color;
                    o_cmd.x_lo    = XW'(i_pos_x);
                    o_cmd.x_hi    = XW'(x_last);
                    o_cmd.page_lo = PW'(RW'(i_pos_y) >> 3);
                    o_cmd.page_hi = PW'(RW'(y_last) >> 3);
                    o_cmd.bit_lo  = i_pos_y[2:0];
                    o_cmd.bit_hi  = y_last[2:0];
                end
            end
            OP_BLIT: begin
                if (blit_row_ok && (blit_lanes != 8'h00)) begin
                    o_cmd.kind    = K_DRAW;
                    o_cmd.color   = 1'b1;
                    o_cmd.lanes   = blit_lanes;
                    o_cmd.x_lo    = XW'(blit_base);
                    o_cmd.page_lo = PW'(RW'(blit_row) >> 3);
                    o_cmd.page_hi = PW'(RW'(blit_row) >> 3);
                    o_cmd.bit_lo  = blit_row[2:0];
                    o_cmd.bit_hi  = blit_row[2:0];
                end
            end
            OP_READ: begin
                if (x_ok && page_ok) begin
                    o_cmd.kind    = K_READ;
                    o_cmd.x_lo    = XW'(i_pos_x);
                    o_cmd.page_lo = PW'(i_read_page);
                end
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pfde_queue.sv
`default_nettype none

module pfde_queue
    import pfde_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_valid,
    output logic      o_full
);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr;
    logic [QPW-1:0]   r_rd;
    logic [QCW-1:0]   r_count;
    logic [QPW-1:0]   n_wr;
    logic [QPW-1:0]   n_rd;
    logic [QCW-1:0]   n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_valid = r_count != '0;
    assign o_full  = r_count == QCW'(QUEUE_DEPTH);

endmodule

`default_nettype wire

### hw/rtl/pfde_back.sv
`default_nettype none

module pfde_back
    import pfde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_valid,
    output logic            o_pop,
    output logic            o_init,
    output logic            o_done,
    output logic [7:0]      o_read_data
);

    t_state          r_state;
    t_state          n_state;
    t_cmd            r_cmd;
    t_cmd            n_cmd;
    logic [XW-1:0]   r_x;
    logic [XW-1:0]   n_x;
    logic [PW-1:0]   r_page;
    logic [PW-1:0]   n_page;
    logic [2:0]      r_lane;
    logic [2:0]      n_lane;
    logic [AW-1:0]   r_sweep;
    logic [AW-1:0]   n_sweep;
    logic            r_done;
    logic            n_done;
    logic [7:0]      r_data;
    logic [7:0]      n_data;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    logic [XW-1:0]   cur_x;
    logic [7:0]      row_mask;
    logic            sweep_last;
    logic            lane_last;
    logic            fill_last;
    logic            cmd_last;

    pfde_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cur_x      = (r_cmd.kind == K_DRAW) ? r_x + XW'(r_lane) : r_x;
        sweep_last = r_sweep == AW'(STORE_SIZE - 1);
        lane_last  = r_lane == 3'd7;
        fill_last  = (r_x == r_cmd.x_hi) && (r_page == r_cmd.page_hi);
        cmd_last   = (r_cmd.kind == K_DRAW) ? lane_last : fill_last;
        for (int b = 0; b < 8; b++) begin
            row_mask[b] = ((r_page != r_cmd.page_lo) || (3'(b) >= r_cmd.bit_lo))
                          && ((r_page != r_cmd.page_hi) || (3'(b) <= r_cmd.bit_hi));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_CLEAR: n_state = S_CLEAR;
                        K_DRAW,
                        K_FILL,
                        K_READ:  n_state = S_FETCH;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                if (r_cmd.kind == K_DRAW && !r_cmd.lanes[r_lane]) begin
                    n_state = lane_last ? S_IDLE : S_FETCH;
                end else begin
                    n_state = S_MODIFY;
                end
            end
            S_MODIFY: begin
                if (r_cmd.kind == K_READ || cmd_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_x       = r_x;
        n_page    = r_page;
        n_lane    = r_lane;
        n_sweep   = r_sweep;
        n_done    = 1'b0;
        n_data    = 8'h00;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = store_addr(r_page, cur_x);
        ram_wdata = r_cmd.color ? (ram_rdata | row_mask) : (ram_rdata & ~row_mask);
        case (r_state)
            S_INIT,
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep;
                ram_wdata = 8'h00;
                n_sweep   = r_sweep + 1'b1;
                if (sweep_last && r_state == S_CLEAR) begin
                    n_done = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_x     = i_cmd.x_lo;
                    n_page  = i_cmd.page_lo;
                    n_lane  = 3'd0;
                    n_sweep = '0;
                    if (i_cmd.kind == K_NOP) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                if (r_cmd.kind == K_DRAW && !r_cmd.lanes[r_lane]) begin
                    n_lane = r_lane + 3'd1;
                    n_done = lane_last;
                end
            end
            S_MODIFY: begin
                if (r_cmd.kind == K_READ) begin
                    n_done = 1'b1;
                    n_data = ram_rdata;
                end else begin
                    ram_we = 1'b1;
                    n_done = cmd_last;
                    if (r_cmd.kind == K_DRAW) begin
                        n_lane = r_lane + 3'd1;
                    end else if (r_x == r_cmd.x_hi) begin
                        n_x    = r_cmd.x_lo;
                        n_page = r_page + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_x    <= n_x;
        r_page <= n_page;
        r_lane <= n_lane;
        r_data <= n_data;
    end

    assign o_init      = r_state == S_INIT;
    assign o_done      = r_done;
    assign o_read_data = r_data;

endmodule

`default_nettype wire

### hw/rtl/page_framebuffer_draw_engine.sv
`default_nettype none

// Monochrome page frame store (8 pages x 128 columns, one byte per column
// per page, bit 0 the top row) with a small drawing engine. Raise start for
// one command when busy is low; every command gives exactly one o_done pulse
// with o_read_data, in command order, and the receiver cannot stall it.
// o_read_data is the stored byte for a read and zero for everything else.
// Commands are classified and clipped on entry and wait in a two-entry
// queue; busy is high while that queue is full and for the clearing pass
// after reset, which writes all 1024 bytes, one per cycle.
// Each command is paced by the single-port store that every pixel write
// must read and then write, and by the back end stepping through all
// eight lanes of a drawn byte:
//   read            a fetch of the byte, then its return
//   pixel           a fetch and write of the byte, then a step per
//                   remaining lane
//   bitmap byte     a step per lane, plus a write for each set, visible bit
//   fill rectangle  a fetch and a write per covered byte (columns x
//                   pages touched)
//   clear           a sweep that writes every byte
//   clipped away    done straight from idle
// The back end takes the next queued command in the cycle of the strobe.

module page_framebuffer_draw_engine
    import pfde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_op,
    input  wire logic [7:0] i_pos_x,
    input  wire logic [7:0] i_pos_y,
    input  wire logic [7:0] i_span_w,
    input  wire logic [7:0] i_span_h,
    input  wire logic       i_color,
    input  wire logic [7:0] i_bitmap_row,
    input  wire logic [4:0] i_byte_column,
    input  wire logic [7:0] i_bitmap_byte,
    input  wire logic [2:0] i_read_page,
    output logic            o_done,
    output logic [7:0]      o_read_data
);

    // classified command from the front end
    t_cmd front_cmd;
    // head of the queue toward the back end
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_full;
    logic queue_pop;
    logic store_init;
    logic push;

    // an item is taken whenever start meets a free queue slot and the clearing pass after reset is over
    assign push = start && !busy;
    assign busy = queue_full || store_init;

    pfde_front u_front (
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_w      (i_span_w),
        .i_span_h      (i_span_h),
        .i_color       (i_color),
        .i_bitmap_row  (i_bitmap_row),
        .i_byte_column (i_byte_column),
        .i_bitmap_byte (i_bitmap_byte),
        .i_read_page   (i_read_page),
        .o_cmd         (front_cmd)
    );

    pfde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    // back end owns the store: sweeps, read-modify-write and readout
    pfde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_pop       (queue_pop),
        .o_init      (store_init),
        .o_done      (o_done),
        .o_read_data (o_read_data)
    );

endmodule

`default_nettype wire

### tb/sv/page_framebuffer_draw_engine_tb.sv
`timescale 1ns / 100ps

module page_framebuffer_draw_engine_tb;
    import pfde_pkg::*;

    // opcodes that the block must ignore
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    // items in this index window are offered without the sender's random gaps
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST  = 950;

    // one drawing command plus the sender's own pacing flags
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] span_w;
        logic [7:0] span_h;
        logic       color;
        logic [7:0] bitmap_row;
        logic [4:0] byte_column;
        logic [7:0] bitmap_byte;
        logic [2:0] read_page;
        logic       drain_first;
        logic       steady;
    } draw_cmd_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] i_op = '0;
    logic [7:0] i_pos_x = '0;
    logic [7:0] i_pos_y = '0;
    logic [7:0] i_span_w = '0;
    logic [7:0] i_span_h = '0;
    logic       i_color = 1'b0;
    logic [7:0] i_bitmap_row = '0;
    logic [4:0] i_byte_column = '0;
    logic [7:0] i_bitmap_byte = '0;
    logic [2:0] i_read_page = '0;
    logic       o_done;
    logic [7:0] o_read_data;

    // shadow copy of the frame store, one byte per column per page
    logic [7:0] frame_copy [0:STORE_SIZE-1];

    draw_cmd_t  cmd_backlog [$];
    logic [7:0] read_data_due [$];
    draw_cmd_t  on_pins;

    int    queued_count = 0;
    int    accepted_count = 0;
    int    mismatch_count = 0;
    int    nonzero_reads = 0;
    int    op_seen [0:7];
    longint cycle_count = 0;
    longint cycle_limit = 64'h7fff_ffff_ffff_ffff;
    longint cycle_budget = 0;
    logic  drain_next = 1'b0;

    page_framebuffer_draw_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_w      (i_span_w),
        .i_span_h      (i_span_h),
        .i_color       (i_color),
        .i_bitmap_row  (i_bitmap_row),
        .i_byte_column (i_byte_column),
        .i_bitmap_byte (i_bitmap_byte),
        .i_read_page   (i_read_page),
        .o_done        (o_done),
        .o_read_data   (o_read_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction: shadow frame store updated per accepted item
    // ------------------------------------------------------------------

    // set or clear one pixel, silently dropping anything off screen
    function automatic void plot(int x, int y, logic color);
        int idx;
        if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_ROWS) return;
        idx = (y / 8) * SCREEN_WIDTH + x;
        frame_copy[idx][y % 8] = color;
    endfunction

    // apply one command to the shadow store, return the byte it reads back
    function automatic logic [7:0] apply_draw_cmd(draw_cmd_t c);
        logic [7:0] data;
        int col;
        data = 8'h00;
        case (c.op)
            OP_CLEAR: begin
                for (int i = 0; i < STORE_SIZE; i++) frame_copy[i] = 8'h00;
            end
            OP_PIXEL: plot(int'(c.pos_x), int'(c.pos_y), c.color);
            OP_FILL: begin
                // clipped at the right and bottom edges, empty if a span is zero
                for (int r = int'(c.pos_y);
                     r < int'(c.pos_y) + int'(c.span_h) && r < SCREEN_ROWS; r++)
                    for (int x = int'(c.pos_x);
                         x < int'(c.pos_x) + int'(c.span_w) && x < SCREEN_WIDTH; x++)
                        plot(x, r, c.color);
            end
            OP_BLIT: begin
                // bitmap bits past the bitmap's width or height are ignored,
                // zero bits leave the store alone
                if (c.bitmap_row < c.span_h) begin
                    for (int i = 0; i < 8; i++) begin
                        col = int'(c.byte_column) * 8 + i;
                        if (col < int'(c.span_w) && c.bitmap_byte[7-i])
                            plot(int'(c.pos_x) + col, int'(c.pos_y) + int'(c.bitmap_row),
                                 1'b1);
                    end
                end
            end
            OP_READ: begin
                if (int'(c.pos_x) < SCREEN_WIDTH && int'(c.read_page) < PAGE_COUNT)
                    data = frame_copy[int'(c.read_page) * SCREEN_WIDTH + int'(c.pos_x)];
            end
            default: ;
        endcase
        return data;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // column mostly on or just past the screen, sometimes anywhere
    function automatic logic [7:0] rand_col();
        if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, SCREEN_WIDTH + 7));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_row();
        if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, SCREEN_ROWS + 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // bitmap and read-page fields random, so that fields a command does not use are exercised
    function automatic draw_cmd_t make_cmd(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                           logic [7:0] w, logic [7:0] h, logic color);
        draw_cmd_t c;
        c.op          = op;
        c.pos_x       = x;
        c.pos_y       = y;
        c.span_w      = w;
        c.span_h      = h;
        c.color       = color;
        c.bitmap_row  = 8'($urandom_range(0, 255));
        c.byte_column = 5'($urandom_range(0, 31));
        c.bitmap_byte = 8'($urandom_range(0, 255));
        c.read_page   = 3'($urandom_range(0, 7));
        c.drain_first = 1'b0;
        c.steady      = 1'b0;
        return c;
    endfunction

    // upper bound on the cycles one command can take inside the block
    function automatic longint worst_cycles(draw_cmd_t c);
        int cols;
        int rows;
        if (c.op == OP_CLEAR) return STORE_SIZE + 16;
        if (c.op == OP_FILL) begin
            cols = (int'(c.span_w) < SCREEN_WIDTH) ? int'(c.span_w) : SCREEN_WIDTH;
            rows = (int'(c.span_h) < SCREEN_ROWS) ? int'(c.span_h) : SCREEN_ROWS;
            return 2 * (cols + 1) * (rows / 8 + 2) + 16;
        end
        return 24;
    endfunction

    task automatic queue_cmd(draw_cmd_t c);
        c.drain_first = drain_next;
        c.steady = (queued_count >= STEADY_FIRST && queued_count <= STEADY_LAST);
        drain_next = 1'b0;
        cmd_backlog.push_back(c);
        // include room for the sender's random gaps
        cycle_budget += worst_cycles(c) + 40;
        queued_count++;
    endtask

    // ------------------------------------------------------------------
    // driver: offers the backlog, one item per handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        logic offer;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            offer = !start;
            if (start && !busy) begin
                // item taken at this edge
                read_data_due.push_back(apply_draw_cmd(on_pins));
                op_seen[on_pins.op]++;
                accepted_count++;
                offer = 1'b1;
            end
            if (offer) begin
                if (cmd_backlog.size() == 0 ||
                    (cmd_backlog[0].drain_first && read_data_due.size() != 0) ||
                    (!cmd_backlog[0].steady && $urandom_range(0, 99) < 36)) begin
                    start <= 1'b0;
                end else begin
                    on_pins = cmd_backlog.pop_front();
                    start         <= 1'b1;
                    i_op          <= on_pins.op;
                    i_pos_x       <= on_pins.pos_x;
                    i_pos_y       <= on_pins.pos_y;
                    i_span_w      <= on_pins.span_w;
                    i_span_h      <= on_pins.span_h;
                    i_color       <= on_pins.color;
                    i_bitmap_row  <= on_pins.bitmap_row;
                    i_byte_column <= on_pins.byte_column;
                    i_bitmap_byte <= on_pins.bitmap_byte;
                    i_read_page   <= on_pins.read_page;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done strobe is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic [7:0] want;
        if (i_rst_n && o_done) begin
            if (read_data_due.size() == 0) begin
                $error("read_data: expected no result, got %02h", o_read_data);
                mismatch_count++;
            end else begin
                want = read_data_due.pop_front();
                if (o_read_data !== want) begin
                    $error("read_data: expected %02h, got %02h", want, o_read_data);
                    mismatch_count++;
                end else if (want != 8'h00) begin
                    nonzero_reads++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        draw_cmd_t c;
        int n_random;
        int pick;
        int last_x;
        int last_y;
        int bw;
        int bh;
        int rows;
        int cols;
        logic [7:0] bx;
        logic [7:0] by;

        for (int i = 0; i < STORE_SIZE; i++) frame_copy[i] = 8'h00;
        for (int i = 0; i < 8; i++) op_seen[i] = 0;

        // --- directed part ---
        // store reads back zero after reset
        c = make_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd0;
        queue_cmd(c);
        // corner pixels, then pixels just off the right, bottom and far corner
        queue_cmd(make_cmd(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        queue_cmd(make_cmd(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1));
        queue_cmd(make_cmd(OP_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1));
        queue_cmd(make_cmd(OP_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1));
        queue_cmd(make_cmd(OP_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1));
        c = make_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd0;
        queue_cmd(c);
        c = make_cmd(OP_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd7;
        queue_cmd(c);
        // read past the last column
        c = make_cmd(OP_READ, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd7;
        queue_cmd(c);
        // rectangle running past both edges, empty rectangles, a clearing fill
        queue_cmd(make_cmd(OP_FILL, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1));
        queue_cmd(make_cmd(OP_FILL, 8'd10, 8'd10, 8'd0, 8'd30, 1'b1));
        queue_cmd(make_cmd(OP_FILL, 8'd10, 8'd10, 8'd30, 8'd0, 1'b1));
        queue_cmd(make_cmd(OP_FILL, 8'd124, 8'd62, 8'd2, 8'd1, 1'b0));
        c = make_cmd(OP_READ, 8'd124, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd7;
        queue_cmd(c);
        // bitmap entirely off screen
        c = make_cmd(OP_BLIT, 8'd250, 8'd0, 8'd255, 8'd255, 1'b0);
        c.bitmap_row = 8'd0; c.byte_column = 5'd0; c.bitmap_byte = 8'hff;
        queue_cmd(c);
        // row below the bitmap's height
        c = make_cmd(OP_BLIT, 8'd20, 8'd20, 8'd8, 8'd4, 1'b0);
        c.bitmap_row = 8'd5; c.byte_column = 5'd0; c.bitmap_byte = 8'hff;
        queue_cmd(c);
        // byte wider than the bitmap
        c = make_cmd(OP_BLIT, 8'd10, 8'd10, 8'd3, 8'd1, 1'b0);
        c.bitmap_row = 8'd0; c.byte_column = 5'd0; c.bitmap_byte = 8'hff;
        queue_cmd(c);
        c = make_cmd(OP_BLIT, 8'd0, 8'd20, 8'd12, 8'd2, 1'b0);
        c.bitmap_row = 8'd1; c.byte_column = 5'd1; c.bitmap_byte = 8'ha5;
        queue_cmd(c);
        // zero bits over a filled area must not clear it
        c = make_cmd(OP_BLIT, 8'd120, 8'd60, 8'd8, 8'd1, 1'b0);
        c.bitmap_row = 8'd0; c.byte_column = 5'd0; c.bitmap_byte = 8'h00;
        queue_cmd(c);
        // last byte column of the widest bitmap, off the right edge
        c = make_cmd(OP_BLIT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
        c.bitmap_row = 8'd255; c.byte_column = 5'd31; c.bitmap_byte = 8'hff;
        queue_cmd(c);
        // spare opcodes do nothing
        queue_cmd(make_cmd(OP_SPARE_5, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1));
        queue_cmd(make_cmd(OP_SPARE_6, 8'd3, 8'd20, 8'd9, 8'd9, 1'b1));
        queue_cmd(make_cmd(OP_SPARE_7, 8'd127, 8'd63, 8'd1, 8'd1, 1'b0));
        c = make_cmd(OP_READ, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd1;
        queue_cmd(c);
        // clear once the engine has gone quiet, then confirm it
        drain_next = 1'b1;
        queue_cmd(make_cmd(OP_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        c = make_cmd(OP_READ, 8'd124, 8'd0, 8'd0, 8'd0, 1'b0); c.read_page = 3'd7;
        queue_cmd(c);

        // --- random part ---
        n_random = 0;
        last_x = 0;
        last_y = 0;
        while (n_random < RANDOM_ITEMS) begin
            // now and then let everything drain before continuing
            if (n_random % 250 > (n_random + 8) % 250) drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                queue_cmd(make_cmd(OP_CLEAR, rand_col(), rand_row(), 8'($urandom),
                                   8'($urandom), 1'($urandom)));
                n_random++;
            end else if (pick < 5) begin
                queue_cmd(make_cmd(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), rand_col(),
                                   rand_row(), 8'($urandom), 8'($urandom), 1'($urandom)));
            end else if (pick < 30) begin
                c = make_cmd(OP_PIXEL, rand_col(), rand_row(), 8'($urandom), 8'($urandom),
                             $urandom_range(0, 3) != 0);
                last_x = c.pos_x;
                last_y = c.pos_y;
                queue_cmd(c);
                n_random++;
            end else if (pick < 45) begin
                // mostly small rectangles, a few with spans anywhere up to 255
                if ($urandom_range(0, 11) == 0)
                    c = make_cmd(OP_FILL, rand_col(), rand_row(), 8'($urandom),
                                 8'($urandom), $urandom_range(0, 9) < 7);
                else
                    c = make_cmd(OP_FILL, rand_col(), rand_row(), 8'($urandom_range(0, 12)),
                                 8'($urandom_range(0, 12)), $urandom_range(0, 9) < 7);
                last_x = c.pos_x;
                last_y = c.pos_y;
                queue_cmd(c);
                n_random++;
            end else if (pick < 65) begin
                // a bitmap sent byte by byte in order, with the odd stray byte
                bx = rand_col();
                by = rand_row();
                bw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(0, 255);
                bh = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 6) : $urandom_range(0, 255);
                rows = (bh < 6) ? bh : 6;
                cols = (bw + 7) / 8;
                if (cols > 4) cols = 4;
                for (int r = 0; r < rows; r++) begin
                    for (int k = 0; k < cols; k++) begin
                        c = make_cmd(OP_BLIT, bx, by, 8'(bw), 8'(bh), 1'($urandom));
                        c.bitmap_row  = 8'(r);
                        c.byte_column = 5'(k);
                        queue_cmd(c);
                        n_random++;
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    c = make_cmd(OP_BLIT, bx, by, 8'(bw), 8'(bh), 1'($urandom));
                    if ($urandom_range(0, 1) == 0 && bh < 255)
                        c.bitmap_row = 8'($urandom_range(bh, 255));
                    queue_cmd(c);
                    n_random++;
                end
                last_x = bx;
                last_y = by;
                // read back what was just drawn
                for (int k = 0; k < 3; k++) begin
                    c = make_cmd(OP_READ, 8'(last_x + k), 8'($urandom), 8'($urandom),
                                 8'($urandom), 1'($urandom));
                    c.read_page = 3'(last_y / 8);
                    queue_cmd(c);
                    n_random++;
                end
            end else begin
                // half the reads land near the last thing drawn
                if ($urandom_range(0, 1) == 0) begin
                    c = make_cmd(OP_READ, 8'(last_x + $urandom_range(0, 7) - 3), rand_row(),
                                 8'($urandom), 8'($urandom), 1'($urandom));
                    c.read_page = 3'(last_y / 8);
                end else begin
                    c = make_cmd(OP_READ, rand_col(), rand_row(), 8'($urandom),
                                 8'($urandom), 1'($urandom));
                end
                queue_cmd(c);
                n_random++;
            end
        end

        // generous bound: every item at its slowest, plus the clearing pass
        cycle_limit = 4 * (cycle_budget + 2 * STORE_SIZE) + 20000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count != queued_count || read_data_due.size() != 0)
            @(posedge i_clk);
        // let any stray strobe show up
        repeat (64) @(posedge i_clk);

        $display("%0d items: %0d clears, %0d pixels, %0d fills, %0d bitmap bytes, %0d reads",
                 accepted_count, op_seen[OP_CLEAR], op_seen[OP_PIXEL], op_seen[OP_FILL],
                 op_seen[OP_BLIT], op_seen[OP_READ]);
        $display("%0d spare opcodes, %0d reads returned set pixels, %0d cycles",
                 op_seen[OP_SPARE_5] + op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7],
                 nonzero_reads, cycle_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
